/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Port assertion failed.");

// Checks that the consequent follows the antecedent in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  `ASSERT_CLK(label, (ante) |-> (cons))

`endif

/* rtl/rhc_pkg.sv */
// Package with the constants, types and divider step of the RGB to HSV converter.
package rhc_pkg;

  localparam int FRAC_BITS = 6;
  localparam int CH_W      = 8;
  localparam int HUE_W     = 15;
  localparam int SAT_W     = 13;

  localparam int SAT_SCALE = 100 * (1 << FRAC_BITS);
  localparam int HUE_SCALE = 60 * (1 << FRAC_BITS);
  localparam int HUE_FULL  = 360 * (1 << FRAC_BITS);
  localparam int CH_MAX    = (1 << CH_W) - 1;

  localparam int QUO_W = $clog2(SAT_SCALE + 1);
  localparam int DIV_W = $clog2(CH_MAX * SAT_SCALE + 1);

  localparam int HCALC_RAW = $clog2(HUE_FULL + 1);
  localparam int HCALC_W   = (HCALC_RAW > HUE_W) ? HCALC_RAW : HUE_W;
  localparam int SCALC_W   = (QUO_W > SAT_W) ? QUO_W : SAT_W;

  localparam int LATENCY = QUO_W + 2;

  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef logic [CH_W-1:0]    rhc_ch_t;
  typedef logic [DIV_W-1:0]   rhc_rem_t;
  typedef logic [QUO_W-1:0]   rhc_quo_t;
  typedef logic [HCALC_W-1:0] rhc_hcalc_t;
  typedef logic [SCALC_W-1:0] rhc_scalc_t;

  typedef struct packed {
    rhc_rem_t rem;
    rhc_rem_t den;
    rhc_quo_t quo;
  } rhc_div_t;

  typedef struct packed {
    rhc_div_t   sat;
    rhc_div_t   hue;
    rhc_ch_t    val;
    logic [1:0] sector;
    logic       neg;
  } rhc_item_t;

  // One restoring step: the divisor is pre-shifted and moves right each step.
  function automatic rhc_div_t div_step(input rhc_div_t d);
    rhc_div_t o;
    o.den = d.den >> 1;
    if (d.rem >= d.den) begin
      o.rem = d.rem - d.den;
      o.quo = {d.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = d.rem;
      o.quo = {d.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* rtl/rhc_front.sv */
// Front cell: finds max, min, sector and scaled dividends of one pixel.
module rhc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_ok,
  input  rhc_pkg::rhc_ch_t  red,
  input  rhc_pkg::rhc_ch_t  green,
  input  rhc_pkg::rhc_ch_t  blue,
  output logic              out_ok,
  output rhc_pkg::rhc_item_t item
);

  rhc_pkg::rhc_ch_t   mx;
  rhc_pkg::rhc_ch_t   mn;
  rhc_pkg::rhc_ch_t   delta;
  rhc_pkg::rhc_ch_t   mx_safe;
  rhc_pkg::rhc_ch_t   delta_safe;
  logic [8:0]         diff_s;
  logic [8:0]         diff_mag;
  rhc_pkg::rhc_item_t item_nxt;
  rhc_pkg::rhc_item_t item_r;
  logic               ok_r;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    mx_safe    = (mx == '0) ? rhc_pkg::rhc_ch_t'(1) : mx;
    delta_safe = (delta == '0) ? rhc_pkg::rhc_ch_t'(1) : delta;

    if (red == mx) begin
      item_nxt.sector = rhc_pkg::SECT_RED;
      diff_s = {1'b0, green} - {1'b0, blue};
    end else if (green == mx) begin
      item_nxt.sector = rhc_pkg::SECT_GREEN;
      diff_s = {1'b0, blue} - {1'b0, red};
    end else begin
      item_nxt.sector = rhc_pkg::SECT_BLUE;
      diff_s = {1'b0, red} - {1'b0, green};
    end
    item_nxt.neg = diff_s[8];
    diff_mag = diff_s[8] ? (~diff_s + 9'd1) : diff_s;

    item_nxt.val     = mx;
    item_nxt.sat.rem = rhc_pkg::rhc_rem_t'(32'(delta) * rhc_pkg::SAT_SCALE);
    item_nxt.sat.den = rhc_pkg::rhc_rem_t'(mx_safe) << (rhc_pkg::QUO_W - 1);
    item_nxt.sat.quo = '0;
    item_nxt.hue.rem = rhc_pkg::rhc_rem_t'(32'(diff_mag[7:0]) * rhc_pkg::HUE_SCALE);
    item_nxt.hue.den = rhc_pkg::rhc_rem_t'(delta_safe) << (rhc_pkg::QUO_W - 1);
    item_nxt.hue.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_ok = ok_r;
  assign item   = item_r;

endmodule

/* rtl/rhc_cell.sv */
// Divider cell: one quotient bit for the saturation and the hue lanes.
module rhc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_ok,
  input  rhc_pkg::rhc_item_t in_item,
  output logic               out_ok,
  output rhc_pkg::rhc_item_t out_item
);

  rhc_pkg::rhc_item_t item_nxt;
  rhc_pkg::rhc_item_t item_r;
  logic               ok_r;

  always_comb begin
    item_nxt     = in_item;
    item_nxt.sat = rhc_pkg::div_step(in_item.sat);
    item_nxt.hue = rhc_pkg::div_step(in_item.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_ok   = ok_r;
  assign out_item = item_r;

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter: front cell, divider chain and output stage.
//
//   channel  ports                                   handshake
//   input    in_red, in_green, in_blue               start && !busy
//   result   out_hue, out_saturation, out_brightness out_valid strobe, one cycle
//
// One item can be taken in every cycle while busy is low; each result passes
// through one front cell, one divider cell per quotient bit (13) and the
// output register, in that order.
// Reset is synchronous and empties the chain; busy is high only during reset.
// The receiver cannot stall, so the chain never holds and busy never rises otherwise.
module rgb_to_hsv_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rhc_pkg::CH_W-1:0]       in_red,
  input  logic [rhc_pkg::CH_W-1:0]       in_green,
  input  logic [rhc_pkg::CH_W-1:0]       in_blue,
  output logic                           out_valid,
  output logic [rhc_pkg::HUE_W-1:0]      out_hue,
  output logic [rhc_pkg::SAT_W-1:0]      out_saturation,
  output logic [rhc_pkg::CH_W-1:0]       out_brightness
);

  logic                accept;
  logic                ok_chain   [0:rhc_pkg::QUO_W];
  rhc_pkg::rhc_item_t  item_chain [0:rhc_pkg::QUO_W];
  rhc_pkg::rhc_item_t  last;
  rhc_pkg::rhc_hcalc_t hq;
  rhc_pkg::rhc_hcalc_t hbase;
  rhc_pkg::rhc_hcalc_t hue_nxt;
  rhc_pkg::rhc_scalc_t sat_nxt;
  logic [rhc_pkg::HUE_W-1:0] hue_r;
  logic [rhc_pkg::SAT_W-1:0] sat_r;
  logic [rhc_pkg::CH_W-1:0]  val_r;
  logic                      valid_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  rhc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ok  (accept),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .out_ok (ok_chain[0]),
    .item   (item_chain[0])
  );

  for (genvar i = 0; i < rhc_pkg::QUO_W; i++) begin : g_cell
    rhc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ok    (ok_chain[i]),
      .in_item  (item_chain[i]),
      .out_ok   (ok_chain[i+1]),
      .out_item (item_chain[i+1])
    );
  end

  assign last = item_chain[rhc_pkg::QUO_W];

  always_comb begin
    hq = rhc_pkg::rhc_hcalc_t'(last.hue.quo);
    case (last.sector)
      rhc_pkg::SECT_GREEN: hbase = rhc_pkg::rhc_hcalc_t'(2 * rhc_pkg::HUE_SCALE);
      rhc_pkg::SECT_BLUE:  hbase = rhc_pkg::rhc_hcalc_t'(4 * rhc_pkg::HUE_SCALE);
      default:             hbase = '0;
    endcase
    if (!last.neg) begin
      hue_nxt = hbase + hq;
    end else if (last.sector != rhc_pkg::SECT_RED) begin
      hue_nxt = hbase - hq;
    end else if (hq == '0) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = rhc_pkg::rhc_hcalc_t'(rhc_pkg::HUE_FULL) - hq;
    end
    sat_nxt = rhc_pkg::rhc_scalc_t'(last.sat.quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ok_chain[rhc_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= hue_nxt[rhc_pkg::HUE_W-1:0];
    sat_r <= sat_nxt[rhc_pkg::SAT_W-1:0];
    val_r <= last.val;
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

endmodule

/* rtl/rhc_checker.sv */
// Port checker for the RGB to HSV converter, bound to the top level.
`include "assert_macros.svh"

module rhc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [rhc_pkg::HUE_W-1:0] out_hue,
  input logic [rhc_pkg::SAT_W-1:0] out_saturation,
  input logic [rhc_pkg::CH_W-1:0]  out_brightness
);

  `ASSERT_IMPL(a_latency, start && !busy, ##15 out_valid)
  `ASSERT_IMPL(a_sat_range, out_valid, out_saturation <= rhc_pkg::SAT_SCALE)
  `ASSERT_IMPL(a_hue_range, out_valid, out_hue < rhc_pkg::HUE_FULL)
  `ASSERT_IMPL(a_black, out_valid && out_brightness == '0, out_saturation == '0 && out_hue == '0)
  `ASSERT_IMPL(a_gray_hue, out_valid && out_saturation == '0, out_hue == '0)

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_brightness (out_brightness)
);
